// File: rtl/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants for the posting varint decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int GROUP_BITS  = 7;
  localparam int MAX_GROUPS  = (VALUE_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
  localparam int SUM_W       = GROUP_BITS * MAX_GROUPS;
  localparam int GROUP_W     = $clog2(MAX_GROUPS + 1);
  localparam int SHIFT_W     = $clog2(SUM_W);
  localparam int OUT_W       = 32;

  localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
  localparam logic [7:0] MORE_BIT     = 8'h80;

  typedef enum logic [1:0] {
    KIND_DOC    = 2'd0,
    KIND_COUNT  = 2'd1,
    KIND_OFFSET = 2'd2
  } kind_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] accumulator;
    logic [GROUP_W-1:0]     group_index;
    kind_t                  field_phase;
    logic [VALUE_WIDTH-1:0] offsets_left;
  } dec_state_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] value;
    kind_t            kind;
    logic             record_end;
    logic             overflow;
  } dec_result_t;

endpackage

// File: rtl/pvd_step.sv
// ----------------------------------------------------------------------------
// pvd_step
// Decode one byte against the current state: next state and optional result.
// ----------------------------------------------------------------------------
module pvd_step import pvd_pkg::*; (
  input  dec_state_t  state,
  input  logic [7:0]  code_byte,
  output dec_state_t  state_next,
  output dec_result_t result
);

  logic [GROUP_BITS-1:0]  payload;
  logic                   more;
  kind_t                  phase;
  logic [SHIFT_W-1:0]     shift;
  logic [SUM_W-1:0]       placed;
  logic                   bad;
  logic [VALUE_WIDTH-1:0] num;
  logic [VALUE_WIDTH-1:0] left_dec;

  always_comb begin
    payload = GROUP_BITS'(code_byte & PAYLOAD_MASK);
    more    = (code_byte & MORE_BIT) != 8'h00;
    unique case (state.field_phase)
      KIND_COUNT:  phase = KIND_COUNT;
      KIND_OFFSET: phase = KIND_OFFSET;
      default:     phase = KIND_DOC;
    endcase
    shift  = SHIFT_W'(state.group_index * GROUP_BITS);
    placed = SUM_W'(payload) << shift;
    bad    = 1'b0;
    if (32'(state.group_index) >= MAX_GROUPS) begin
      bad = 1'b1;
    end else begin
      if ((placed >> VALUE_WIDTH) != '0) begin
        bad = 1'b1;
      end
      if (more && (32'(state.group_index) + 1 >= MAX_GROUPS)) begin
        bad = 1'b1;
      end
    end
    num      = state.accumulator | VALUE_WIDTH'(placed);
    left_dec = (state.offsets_left != '0) ? state.offsets_left - 1'b1
                                          : state.offsets_left;

    state_next        = state;
    result.valid      = 1'b0;
    result.value      = '0;
    result.kind       = phase;
    result.record_end = 1'b0;
    result.overflow   = 1'b0;

    priority if (bad) begin
      state_next      = '0;
      result.valid    = 1'b1;
      result.overflow = 1'b1;
    end else if (more) begin
      state_next.accumulator = num;
      state_next.group_index = state.group_index + 1'b1;
    end else begin
      result.valid           = 1'b1;
      result.value           = OUT_W'(num);
      state_next.accumulator = '0;
      state_next.group_index = '0;
      unique case (phase)
        KIND_DOC: begin
          state_next.field_phase = KIND_COUNT;
        end
        KIND_COUNT: begin
          if (num == '0) begin
            result.record_end       = 1'b1;
            state_next.field_phase  = KIND_DOC;
            state_next.offsets_left = '0;
          end else begin
            state_next.offsets_left = num;
            state_next.field_phase  = KIND_OFFSET;
          end
        end
        default: begin
          state_next.offsets_left = left_dec;
          if (left_dec == '0) begin
            result.record_end      = 1'b1;
            state_next.field_phase = KIND_DOC;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/posting_varint_decoder.sv
// ----------------------------------------------------------------------------
// posting_varint_decoder
// Decode LEB128 posting records (doc id, count, offsets) one byte per transfer.
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless a held result stalls the input. A byte is
// captured in the input register, is decoded against the running state in a
// single pass and, when it closes a number or overflows, lands in the result
// register. Continuation bytes give no result. A held result that is not taken
// stalls the byte in the input register.
// Overflow returns the decoder to expecting a document id.
module posting_varint_decoder import pvd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  output logic        code_ready,
  input  logic [7:0]  code_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] value,
  output logic [1:0]  kind,
  output logic        record_end,
  output logic        overflow
);

  logic        byte_valid;
  logic [7:0]  byte_reg;
  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t step_result;
  dec_result_t result;
  logic        advance;

  pvd_step u_step (
    .state      (state),
    .code_byte  (byte_reg),
    .state_next (state_next),
    .result     (step_result)
  );

  assign advance    = byte_valid && (!result.valid || result_ready);
  assign code_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid   <= 1'b0;
      state        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (code_ready) begin
        byte_valid <= code_valid;
      end
      if (advance) begin
        state             <= state_next;
        result.valid      <= step_result.valid;
        result.value      <= step_result.value;
        result.kind       <= step_result.kind;
        result.record_end <= step_result.record_end;
        result.overflow   <= step_result.overflow;
      end else if (result_ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (code_ready && code_valid) begin
      byte_reg <= code_byte;
    end
  end

  assign result_valid = result.valid;
  assign value        = result.value;
  assign kind         = result.kind;
  assign record_end   = result.record_end;
  assign overflow     = result.overflow;

endmodule

// File: tb/posting_varint_decoder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posting_varint_decoder_test
// Self-checking bench for the LEB128 posting record decoder.
// ----------------------------------------------------------------------------
// Code bytes are sent from a queue through a valid/ready driver. A decoder
// model in the bench tracks doc id, count and offset fields and predicts the
// result, if any, of every accepted byte. A monitor compares each result transfer with
// the oldest prediction. The run has a directed opening, then random records
// with zero-group padding, overflow aborts and stray bytes. It runs in three
// phases of sender and receiver stalls, and the sender drains between phases.
// ----------------------------------------------------------------------------
module posting_varint_decoder_test;
  import pvd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 650;
  localparam int LAST_ROOM   = VALUE_WIDTH - (MAX_GROUPS - 1) * GROUP_BITS;
  localparam logic [63:0] VALUE_MASK =
    (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct {
    logic [31:0] value;
    kind_t       kind;
    logic        record_end;
    logic        overflow;
  } posting_result_t;

  logic        clk;
  logic        rst;
  logic        code_valid;
  logic        code_ready;
  logic [7:0]  code_byte;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] value;
  logic [1:0]  kind;
  logic        record_end;
  logic        overflow;

  logic [7:0]      pending_bytes[$];
  posting_result_t expected_results[$];
  posting_result_t due_result;

  int send_idle_pct;
  int recv_idle_pct;
  bit byte_taken;
  int cycle_count;
  int bytes_decoded;
  int results_checked;
  int records_closed;
  int overflows_seen;
  int error_count;

  logic [63:0] acc_bits          = '0;
  int          groups_taken      = 0;
  kind_t       field_kind        = KIND_DOC;
  logic [63:0] offsets_remaining = '0;

  logic [7:0] directed_bytes [25] = '{
    8'h00, 8'h00,
    8'h7f, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f,
    8'h80, 8'h00, 8'h81, 8'h00, 8'h05,
    8'hff, 8'hff, 8'hff, 8'hff, 8'h10,
    8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80
  };

  posting_varint_decoder dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("posting_varint_decoder verification failed");
      $finish;
    end
  end

  task automatic decode_byte(input logic [7:0] b);
    logic [6:0]      payload;
    bit              more;
    bit              bad;
    int              shift;
    int              room;
    posting_result_t res;
    payload = 7'(b & PAYLOAD_MASK);
    more    = (b & MORE_BIT) != 0;
    bad     = 0;
    shift   = 0;
    if (groups_taken >= MAX_GROUPS) begin
      bad = 1;
    end else begin
      shift = groups_taken * GROUP_BITS;
      room  = VALUE_WIDTH - shift;
      if (room < GROUP_BITS && (payload >> room) != 0) bad = 1;
      if (more && groups_taken + 1 >= MAX_GROUPS) bad = 1;
    end
    res.kind       = field_kind;
    res.record_end = 1'b0;
    if (bad) begin
      res.value         = '0;
      res.overflow      = 1'b1;
      acc_bits          = '0;
      groups_taken      = 0;
      field_kind        = KIND_DOC;
      offsets_remaining = '0;
      expected_results.push_back(res);
      return;
    end
    acc_bits = (acc_bits | (64'(payload) << shift)) & VALUE_MASK;
    if (more) begin
      groups_taken++;
      return;
    end
    res.value    = acc_bits[31:0];
    res.overflow = 1'b0;
    case (field_kind)
      KIND_COUNT: begin
        if (acc_bits == 0) begin
          res.record_end    = 1'b1;
          field_kind        = KIND_DOC;
          offsets_remaining = '0;
        end else begin
          offsets_remaining = acc_bits;
          field_kind        = KIND_OFFSET;
        end
      end
      KIND_OFFSET: begin
        if (offsets_remaining != 0) offsets_remaining--;
        if (offsets_remaining == 0) begin
          res.record_end = 1'b1;
          field_kind     = KIND_DOC;
        end
      end
      default: begin
        field_kind = KIND_COUNT;
      end
    endcase
    acc_bits     = '0;
    groups_taken = 0;
    expected_results.push_back(res);
  endtask

  // drive code bytes and result stalls
  always @(negedge clk) begin
    if (!rst) begin
      if (!code_valid || byte_taken) begin
        byte_taken = 0;
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          code_byte  <= pending_bytes.pop_front();
          code_valid <= 1'b1;
        end else begin
          code_valid <= 1'b0;
        end
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // predict on byte transfers, check result transfers
  always @(posedge clk) begin
    if (!rst) begin
      if (code_valid && code_ready) begin
        decode_byte(code_byte);
        byte_taken = 1;
        bytes_decoded++;
      end
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing pending: value %0h kind %0d", value, kind);
          error_count++;
        end else begin
          due_result = expected_results.pop_front();
          if (value !== due_result.value) begin
            $error("value expected %0h actual %0h", due_result.value, value);
            error_count++;
          end
          if (kind !== due_result.kind) begin
            $error("kind expected %0d actual %0d", due_result.kind, kind);
            error_count++;
          end
          if (record_end !== due_result.record_end) begin
            $error("record_end expected %0b actual %0b", due_result.record_end, record_end);
            error_count++;
          end
          if (overflow !== due_result.overflow) begin
            $error("overflow expected %0b actual %0b", due_result.overflow, overflow);
            error_count++;
          end
          results_checked++;
          if (due_result.record_end) records_closed++;
          if (due_result.overflow) overflows_seen++;
        end
      end
    end
  end

  function automatic logic [63:0] random_value();
    int bits;
    if ($urandom_range(9) == 0) return VALUE_MASK & 64'hffff_ffff;
    bits = $urandom_range(0, (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);
    if (bits == 0) return '0;
    return {32'b0, $urandom} >> (32 - bits);
  endfunction

  task automatic push_number(input logic [63:0] num, input bit pad);
    int need;
    int total;
    logic [7:0] b;
    need = 1;
    while (need < MAX_GROUPS && (num >> (GROUP_BITS * need)) != 0) need++;
    total = (pad && need < MAX_GROUPS) ? $urandom_range(need + 1, MAX_GROUPS) : need;
    for (int i = 0; i < total; i++) begin
      b = 8'((num >> (GROUP_BITS * i)) & 64'(PAYLOAD_MASK));
      if (i < total - 1) b = b | MORE_BIT;
      pending_bytes.push_back(b);
    end
  endtask

  task automatic fill_random(input int n_bytes);
    int         sel;
    int         count;
    int         stage;
    logic [7:0] last;
    while (pending_bytes.size() < n_bytes) begin
      sel = $urandom_range(99);
      if (sel < 78) begin
        count = ($urandom_range(19) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
        push_number(random_value(), $urandom_range(4) == 0);
        push_number(64'(count), $urandom_range(4) == 0);
        repeat (count) push_number(random_value(), $urandom_range(4) == 0);
      end else if (sel < 90) begin
        stage = $urandom_range(2);
        if (stage > 0) push_number(random_value(), 0);
        if (stage > 1) push_number(64'($urandom_range(1, 5)), 0);
        repeat (MAX_GROUPS - 1) pending_bytes.push_back(MORE_BIT | 8'($urandom_range(0, 127)));
        if (LAST_ROOM < GROUP_BITS && $urandom_range(1) == 1) begin
          last = 8'($urandom_range(1 << LAST_ROOM, 127));
          if ($urandom_range(1) == 1) last = last | MORE_BIT;
        end else begin
          last = MORE_BIT | 8'($urandom_range(0, 127));
        end
        pending_bytes.push_back(last);
      end else begin
        repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic drain_all();
    while (pending_bytes.size() != 0 || code_valid) @(posedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    code_valid    = 1'b0;
    code_byte     = '0;
    result_ready  = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 76;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_bytes[i]) pending_bytes.push_back(directed_bytes[i]);
    fill_random(PHASE_BYTES);
    drain_all();

    @(posedge clk);
    send_idle_pct = 76;
    recv_idle_pct = 29;
    fill_random(PHASE_BYTES);
    drain_all();

    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(PHASE_BYTES);
    drain_all();

    repeat (8) @(negedge clk);
    $display("Decoded %0d code bytes into %0d checked results over three stall phases.",
             bytes_decoded, results_checked);
    $display("Closed %0d posting records and caught %0d overflow aborts; %0d mismatches.",
             records_closed, overflows_seen, error_count);
    if (error_count == 0) begin
      $display("posting_varint_decoder verification clean");
    end else begin
      $display("posting_varint_decoder verification failed");
    end
    $finish;
  end

endmodule
